// File: design/hbbc_pkg.sv
// Package with shared constants, codes and types of the block buffer cache.
`default_nettype none
package hbbc_pkg;
	localparam int BucketCountDefault = 31;
	localparam int BufferCountDefault = 30;
	localparam int SlotW = 5;

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN = 2'd2,
		OP_UNPIN = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_BUFFER = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;
endpackage
`default_nettype wire

// File: design/hbbc_mod.sv
// Modulo unit: reduces a 32-bit value by a constant divisor with a reciprocal multiply.
`default_nettype none
module hbbc_mod #(
	parameter int DIVISOR = hbbc_pkg::BucketCountDefault,
	localparam int RW = $clog2(DIVISOR)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   value,
	output logic               done,
	output logic [RW-1:0]      remainder
);
	// Rounded-up reciprocal of the divisor scaled by 2**(32+RW); it fits in 33 bits
	// and gives the exact quotient for every 32-bit value.
	localparam logic [63:0] MAGIC =
		((64'd1 << (32 + RW)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [31:0]   value_q;
	logic [31:0]   quot_q;
	logic [RW-1:0] rem_q;
	logic          quot_step_q;
	logic          rem_step_q;
	logic [64:0]   product;
	logic [31:0]   back;
	logic [31:0]   rem_full;

	// The quotient is registered first, the remainder in the next cycle.
	assign product = {33'd0, value_q} * {32'd0, MAGIC[32:0]};
	assign back = quot_q * 32'(DIVISOR);
	assign rem_full = value_q - back;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_step_q <= 1'b0;
			rem_step_q <= 1'b0;
			done <= 1'b0;
		end else begin
			quot_step_q <= start;
			rem_step_q <= quot_step_q && !start;
			done <= rem_step_q && !start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) value_q <= value;
		if (quot_step_q) quot_q <= 32'(product[64:32+RW]);
		if (rem_step_q) rem_q <= rem_full[RW-1:0];
	end
endmodule
`default_nettype wire

// File: design/hashed_block_buffer_cache.sv
// Top level of the block buffer cache manager with its hash index and sequencer.
// Usage: a request enters on req_valid/req_ready with operation, device,
// block_number, buffer_slot and now_tick. Exactly one result leaves on
// rsp_valid/rsp_ready with slot_out, hit, needs_fill and status.
// Release, pin and unpin raise rsp_valid in the cycle after acceptance. A get
// first reduces block_number modulo the bucket count with a reciprocal
// multiply, then probes the index, issuing the read for an entry and then
// checking it, at most BUCKET_COUNT entries; a hit adds a state for the count
// update. A miss then scans the buffers one a cycle, reduces the victim's old
// block number if the victim is mapped, probes for its entry and for a free
// entry (each up to BUCKET_COUNT entries), and writes back. One request is
// handled at a time; req_ready is low while one is in work or while its result
// waits, and rises the cycle after the result is taken. A stalled receiver
// simply holds the result register and the block waits. Reset marks all index
// entries invalid and all buffers unmapped, unreferenced, unfilled and stamped
// with time zero; a request is taken right after reset.
`default_nettype none
module hashed_block_buffer_cache #(
	parameter int BUCKET_COUNT = hbbc_pkg::BucketCountDefault,
	parameter int BUFFER_COUNT = hbbc_pkg::BufferCountDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  device,
	input  wire logic [31:0] block_number,
	input  wire logic [4:0]  buffer_slot,
	input  wire logic [31:0] now_tick,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [4:0]       slot_out,
	output logic             hit,
	output logic             needs_fill,
	output logic [1:0]       status
);
	localparam int IW = $clog2(BUCKET_COUNT);
	localparam int BW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
	localparam int CW = $clog2(BUCKET_COUNT + 1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_MOD1  = 11'b00000000010,
		S_PROBE = 11'b00000000100,
		S_HITUP = 11'b00000001000,
		S_SCAN  = 11'b00000010000,
		S_MOD2  = 11'b00000100000,
		S_FINDO = 11'b00001000000,
		S_MOD3  = 11'b00010000000,
		S_FINDN = 11'b00100000000,
		S_COMMIT= 11'b01000000000,
		S_SMALL = 11'b10000000000
	} state_t;

	// Index entry: valid, device, block number, buffer slot.
	typedef struct packed {
		logic        valid;
		logic [7:0]  dev;
		logic [31:0] bn;
		logic [BW-1:0] slot;
	} entry_t;

	state_t state_q;

	// Buffer state lives in flip-flops, read at the slot that each state selects.
	logic [39:0] tag_q [BUFFER_COUNT];
	logic [BUFFER_COUNT-1:0] mapped_q, filled_q;
	logic [7:0]  ref_q [BUFFER_COUNT];
	logic [31:0] last_q [BUFFER_COUNT];

	// Hash index memory with registered read.
	entry_t idx_mem [BUCKET_COUNT];
	logic [BUCKET_COUNT-1:0] idx_valid_q;
	entry_t rd_data_q;
	logic   rd_valid_q;
	logic [IW-1:0] rd_addr_q;

	logic [1:0]  op_q;
	logic [7:0]  dev_q;
	logic [31:0] bn_q;
	logic [4:0]  slot_in_q;
	logic [31:0] now_q;

	logic [IW-1:0] pos_q, home_q;
	logic [CW-1:0] steps_q;
	logic          rd_pending_q;
	logic [BW-1:0] scan_q, victim_q;
	logic          have_victim_q;
	logic [31:0]   best_q;
	logic          old_found_q;
	logic [IW-1:0] old_pos_q;
	logic [BW-1:0] hit_slot_q;

	logic          mod_start, mod_done;
	logic [31:0]   mod_value;
	logic [IW-1:0] mod_rem;

	hbbc_mod #(.DIVISOR(BUCKET_COUNT)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .value(mod_value),
		.done(mod_done), .remainder(mod_rem)
	);

	logic [IW-1:0] pos_next;
	assign pos_next = (pos_q == IW'(BUCKET_COUNT - 1)) ? '0 : pos_q + IW'(1);

	logic        idx_we;
	logic [IW-1:0] idx_wa;
	entry_t      idx_wd;
	logic        idx_clr;
	logic [IW-1:0] idx_ca;

	logic slot_ok;
	assign slot_ok = ({1'b0, slot_in_q} < 6'(BUFFER_COUNT));
	logic [BW-1:0] sslot;
	assign sslot = slot_in_q[BW-1:0];

	assign req_ready = (state_q == S_IDLE) && !rsp_valid;

	always_ff @(posedge clk) begin
		if (idx_we) idx_mem[idx_wa] <= idx_wd;
		rd_data_q <= idx_mem[pos_q];
		rd_addr_q <= pos_q;
	end

	always_comb begin
		mod_start = 1'b0;
		mod_value = bn_q;
		if (state_q == S_IDLE && req_valid && req_ready &&
		    operation == hbbc_pkg::OP_GET) begin
			mod_start = 1'b1;
			mod_value = block_number;
		end else if (state_q == S_SCAN && scan_q == BW'(BUFFER_COUNT - 1) &&
		             mapped_q[have_victim_q ? victim_q : scan_q]) begin
			mod_start = 1'b0;
		end
		if (state_q == S_MOD2 && !rd_pending_q) begin
			mod_start = 1'b1;
			mod_value = tag_q[victim_q][31:0];
		end
		if (state_q == S_MOD3 && !rd_pending_q) begin
			mod_start = 1'b1;
			mod_value = bn_q;
		end
	end

	// Candidate test for the victim scan.
	logic cand;
	assign cand = (ref_q[scan_q] == 8'd0) && (last_q[scan_q] <= now_q) &&
	              (!have_victim_q || last_q[scan_q] < best_q);

	entry_t rd_e;
	logic   rd_ok;
	assign rd_e = rd_data_q;
	assign rd_ok = rd_valid_q;

	always_comb begin
		idx_we = 1'b0;
		idx_wa = pos_q;
		idx_wd = '{valid: 1'b1, dev: dev_q, bn: bn_q, slot: victim_q};
		idx_clr = 1'b0;
		idx_ca = old_pos_q;
		if (state_q == S_COMMIT) begin
			idx_we = 1'b1;
			idx_clr = old_found_q && (old_pos_q != pos_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid <= 1'b0;
			idx_valid_q <= '0;
			mapped_q <= '0;
			filled_q <= '0;
			rd_pending_q <= 1'b0;
			rd_valid_q <= 1'b0;
			for (int i = 0; i < BUFFER_COUNT; i++) begin
				tag_q[i] <= '0;
				ref_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else begin
			rd_valid_q <= idx_valid_q[pos_q];
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
			// The old entry of the victim is dropped as the new one is written.
			if (idx_we)
				idx_valid_q <= (idx_valid_q &
				                ~(idx_clr ? (BUCKET_COUNT'(1) << idx_ca) : '0)) |
				               (BUCKET_COUNT'(1) << idx_wa);
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						op_q <= operation; dev_q <= device; bn_q <= block_number;
						slot_in_q <= buffer_slot; now_q <= now_tick;
						state_q <= (operation == hbbc_pkg::OP_GET) ? S_MOD1 : S_SMALL;
					end
				end
				S_SMALL: begin
					slot_out <= slot_in_q; hit <= 1'b0; needs_fill <= 1'b0;
					status <= hbbc_pkg::ST_OK;
					if (slot_ok) begin
						if (op_q == hbbc_pkg::OP_PIN) begin
							if (ref_q[sslot] != 8'hFF) ref_q[sslot] <= ref_q[sslot] + 8'd1;
						end else if (ref_q[sslot] == 8'd0) begin
							status <= hbbc_pkg::ST_UNDERFLOW;
						end else begin
							ref_q[sslot] <= ref_q[sslot] - 8'd1;
							if (op_q == hbbc_pkg::OP_RELEASE && ref_q[sslot] == 8'd1)
								last_q[sslot] <= now_q;
						end
					end
					rsp_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MOD1: begin
					if (mod_done) begin
						pos_q <= mod_rem; home_q <= mod_rem;
						steps_q <= '0; rd_pending_q <= 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					// A cycle with rd_pending_q set issues the read at pos_q, the next checks it.
					if (rd_pending_q) begin
						rd_pending_q <= 1'b0;
					end else if (rd_ok && rd_e.dev == dev_q && rd_e.bn == bn_q &&
					             {1'b0, rd_e.slot} < (BW+1)'(BUFFER_COUNT)) begin
						hit_slot_q <= rd_e.slot;
						state_q <= S_HITUP;
					end else if (steps_q == CW'(BUCKET_COUNT - 1)) begin
						scan_q <= '0; have_victim_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						steps_q <= steps_q + CW'(1);
						pos_q <= pos_next; rd_pending_q <= 1'b1;
					end
				end
				S_HITUP: begin
					slot_out <= 5'(hit_slot_q); hit <= 1'b1;
					needs_fill <= !filled_q[hit_slot_q]; status <= hbbc_pkg::ST_OK;
					if (ref_q[hit_slot_q] != 8'hFF)
						ref_q[hit_slot_q] <= ref_q[hit_slot_q] + 8'd1;
					filled_q[hit_slot_q] <= 1'b1;
					rsp_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (cand) begin
						victim_q <= scan_q; best_q <= last_q[scan_q];
						have_victim_q <= 1'b1;
					end
					if (scan_q == BW'(BUFFER_COUNT - 1)) begin
						if (!(cand || have_victim_q)) begin
							slot_out <= '0; hit <= 1'b0; needs_fill <= 1'b0;
							status <= hbbc_pkg::ST_NO_BUFFER;
							rsp_valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							old_found_q <= 1'b0;
							rd_pending_q <= 1'b0;
							state_q <= S_MOD2;
						end
					end else begin
						scan_q <= scan_q + BW'(1);
					end
				end
				S_MOD2: begin
					// rd_pending_q marks that the modulo unit was started.
					if (!mapped_q[victim_q]) begin
						rd_pending_q <= 1'b0;
						state_q <= S_MOD3;
					end else if (!rd_pending_q) begin
						rd_pending_q <= 1'b1;
					end else if (mod_done) begin
						pos_q <= mod_rem; steps_q <= '0;
						state_q <= S_FINDO;
					end
				end
				S_FINDO: begin
					if (rd_pending_q) begin
						rd_pending_q <= 1'b0;
					end else if (rd_ok && rd_e.dev == tag_q[victim_q][39:32] &&
					             rd_e.bn == tag_q[victim_q][31:0] &&
					             rd_e.slot == victim_q) begin
						old_found_q <= 1'b1; old_pos_q <= rd_addr_q;
						state_q <= S_MOD3;
					end else if (steps_q == CW'(BUCKET_COUNT - 1)) begin
						state_q <= S_MOD3;
					end else begin
						steps_q <= steps_q + CW'(1);
						pos_q <= pos_next; rd_pending_q <= 1'b1;
					end
				end
				S_MOD3: begin
					// The home bucket of the new block is still in home_q.
					pos_q <= home_q; steps_q <= '0; rd_pending_q <= 1'b1;
					state_q <= S_FINDN;
				end
				S_FINDN: begin
					if (rd_pending_q) begin
						rd_pending_q <= 1'b0;
					end else if (!rd_ok || (old_found_q && rd_addr_q == old_pos_q)) begin
						state_q <= S_COMMIT;
					end else if (steps_q == CW'(BUCKET_COUNT - 1)) begin
						slot_out <= '0; hit <= 1'b0; needs_fill <= 1'b0;
						status <= hbbc_pkg::ST_NO_BUFFER;
						rsp_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						steps_q <= steps_q + CW'(1);
						pos_q <= pos_next; rd_pending_q <= 1'b1;
					end
				end
				S_COMMIT: begin
					tag_q[victim_q] <= {dev_q, bn_q};
					mapped_q[victim_q] <= 1'b1;
					ref_q[victim_q] <= 8'd1;
					filled_q[victim_q] <= 1'b1;
					slot_out <= 5'(victim_q); hit <= 1'b0; needs_fill <= 1'b1;
					status <= hbbc_pkg::ST_OK;
					rsp_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the hashed block buffer cache manager.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBUCKET = 31;
	localparam int NBUF = 30;

	// One expected response of the cache.
	typedef struct packed {
		logic [4:0] slot;
		logic       hit;
		logic       fill;
		hbbc_pkg::status_t status;
	} cache_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	hbbc_pkg::op_t operation = hbbc_pkg::OP_GET;
	logic [7:0] device = '0;
	logic [31:0] block_number = '0;
	logic [4:0] buffer_slot = '0;
	logic [31:0] now_tick = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [4:0] slot_out;
	logic hit;
	logic needs_fill;
	logic [1:0] status;

	// Shadow copy of the cache state, updated as each request is accepted.
	logic        idx_valid [NBUCKET];
	logic [7:0]  idx_dev [NBUCKET];
	logic [31:0] idx_block [NBUCKET];
	logic [4:0]  idx_buf [NBUCKET];
	logic [7:0]  tag_dev [NBUF];
	logic [31:0] tag_block [NBUF];
	logic        buf_mapped [NBUF];
	logic [7:0]  buf_refs [NBUF];
	logic [31:0] buf_stamp [NBUF];
	logic        buf_filled [NBUF];

	cache_rsp_t pending_rsp[$];
	int mismatches = 0;
	bit quiet = 1'b0;
	logic [31:0] clock_now = 32'd100;

	hashed_block_buffer_cache uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .device(device), .block_number(block_number),
		.buffer_slot(buffer_slot), .now_tick(now_tick),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.slot_out(slot_out), .hit(hit), .needs_fill(needs_fill), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The response side stalls about one cycle in eight unless a quiet stretch runs.
	always @(posedge clk) begin
		rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
	end

	// Each accepted response is compared with the oldest prediction.
	always @(posedge clk) begin
		cache_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response slot=%0d hit=%0b fill=%0b status=%0d",
						slot_out, hit, needs_fill, status);
			end else begin
				want = pending_rsp.pop_front();
				if (slot_out !== want.slot || hit !== want.hit ||
				    needs_fill !== want.fill || status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want slot=%0d hit=%0b fill=%0b status=%0d, %s",
							want.slot, want.hit, want.fill, want.status,
							$sformatf("got slot=%0d hit=%0b fill=%0b status=%0d",
							slot_out, hit, needs_fill, status));
				end
			end
		end
	end

	// Clears the shadow state to its post-reset contents.
	task automatic clear_shadow();
		for (int i = 0; i < NBUCKET; i++) begin
			idx_valid[i] = 1'b0;
			idx_dev[i] = '0;
			idx_block[i] = '0;
			idx_buf[i] = '0;
		end
		for (int i = 0; i < NBUF; i++) begin
			tag_dev[i] = '0;
			tag_block[i] = '0;
			buf_mapped[i] = 1'b0;
			buf_refs[i] = '0;
			buf_stamp[i] = '0;
			buf_filled[i] = 1'b0;
		end
	endtask

	// A get looks the block up in the index; a miss recycles the least recently
	// released idle buffer and moves its index entry.
	function automatic cache_rsp_t lookup_or_evict(logic [7:0] dev, logic [31:0] blk,
			logic [31:0] now);
		cache_rsp_t r;
		int pos;
		int victim;
		int old_pos;
		int new_pos;
		logic [31:0] oldest;
		r = '{slot: '0, hit: 1'b0, fill: 1'b0, status: hbbc_pkg::ST_OK};
		victim = -1;
		old_pos = -1;
		new_pos = -1;
		oldest = '0;
		pos = blk % NBUCKET;
		for (int j = 0; j < NBUCKET; j++) begin
			if (idx_valid[pos] && idx_dev[pos] == dev && idx_block[pos] == blk &&
			    idx_buf[pos] < NBUF) begin
				r.slot = idx_buf[pos];
				r.hit = 1'b1;
				r.fill = !buf_filled[idx_buf[pos]];
				if (buf_refs[idx_buf[pos]] != 8'hFF)
					buf_refs[idx_buf[pos]]++;
				buf_filled[idx_buf[pos]] = 1'b1;
				return r;
			end
			pos = (pos + 1) % NBUCKET;
		end
		for (int i = 0; i < NBUF; i++)
			if (buf_refs[i] == 0 && buf_stamp[i] <= now &&
			    (victim < 0 || buf_stamp[i] < oldest)) begin
				victim = i;
				oldest = buf_stamp[i];
			end
		r.status = hbbc_pkg::ST_NO_BUFFER;
		if (victim < 0)
			return r;
		if (buf_mapped[victim]) begin
			pos = tag_block[victim] % NBUCKET;
			for (int j = 0; j < NBUCKET && old_pos < 0; j++) begin
				if (idx_valid[pos] && idx_dev[pos] == tag_dev[victim] &&
				    idx_block[pos] == tag_block[victim] && idx_buf[pos] == victim)
					old_pos = pos;
				pos = (pos + 1) % NBUCKET;
			end
		end
		pos = blk % NBUCKET;
		for (int j = 0; j < NBUCKET && new_pos < 0; j++) begin
			if (!idx_valid[pos] || pos == old_pos)
				new_pos = pos;
			pos = (pos + 1) % NBUCKET;
		end
		if (new_pos < 0)
			return r;
		if (old_pos >= 0)
			idx_valid[old_pos] = 1'b0;
		idx_valid[new_pos] = 1'b1;
		idx_dev[new_pos] = dev;
		idx_block[new_pos] = blk;
		idx_buf[new_pos] = victim[4:0];
		tag_dev[victim] = dev;
		tag_block[victim] = blk;
		buf_mapped[victim] = 1'b1;
		buf_refs[victim] = 8'd1;
		buf_filled[victim] = 1'b1;
		r = '{slot: victim[4:0], hit: 1'b0, fill: 1'b1, status: hbbc_pkg::ST_OK};
		return r;
	endfunction

	// Predicts the response of one request and updates the shadow state.
	function automatic cache_rsp_t predict_cache(hbbc_pkg::op_t op, logic [7:0] dev,
			logic [31:0] blk, logic [4:0] slot, logic [31:0] now);
		cache_rsp_t r;
		r = '{slot: slot, hit: 1'b0, fill: 1'b0, status: hbbc_pkg::ST_OK};
		if (op == hbbc_pkg::OP_GET)
			return lookup_or_evict(dev, blk, now);
		if (slot >= NBUF)
			return r;
		if (op == hbbc_pkg::OP_PIN) begin
			if (buf_refs[slot] != 8'hFF)
				buf_refs[slot]++;
		end else if (buf_refs[slot] == 0) begin
			r.status = hbbc_pkg::ST_UNDERFLOW;
		end else begin
			buf_refs[slot]--;
			if (op == hbbc_pkg::OP_RELEASE && buf_refs[slot] == 0)
				buf_stamp[slot] = now;
		end
		return r;
	endfunction

	// Sends one request, with an occasional random gap before it, and records
	// the expected response once the cache takes it.
	task automatic send_request(hbbc_pkg::op_t op, logic [7:0] dev, logic [31:0] blk,
			logic [4:0] slot, logic [31:0] now);
		if (!quiet && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		device <= dev;
		block_number <= blk;
		buffer_slot <= slot;
		now_tick <= now;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(predict_cache(op, dev, blk, slot, now));
	endtask

	// Lowers valid and waits for every outstanding response.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic test_basic_ops();
		send_request(hbbc_pkg::OP_GET, 8'd0, 32'd0, 5'd0, 32'd0);
		send_request(hbbc_pkg::OP_GET, 8'd0, 32'd0, 5'd0, 32'd1);
		send_request(hbbc_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
		// Blocks 31 and 62 share bucket zero with block 0 and probe onward.
		send_request(hbbc_pkg::OP_GET, 8'd0, 32'd31, 5'd0, 32'd2);
		send_request(hbbc_pkg::OP_GET, 8'd1, 32'd62, 5'd0, 32'd2);
		send_request(hbbc_pkg::OP_GET, 8'd0, 32'd31, 5'd0, 32'd3);
		send_request(hbbc_pkg::OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd10);
		send_request(hbbc_pkg::OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd11);
		send_request(hbbc_pkg::OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd12);
		send_request(hbbc_pkg::OP_UNPIN, 8'd0, 32'd0, 5'd29, 32'd12);
		send_request(hbbc_pkg::OP_PIN, 8'd0, 32'd0, 5'd29, 32'd12);
		send_request(hbbc_pkg::OP_UNPIN, 8'd0, 32'd0, 5'd29, 32'd12);
		send_request(hbbc_pkg::OP_RELEASE, 8'd0, 32'd0, 5'd29, 32'd12);
		for (int s = NBUF; s < 32; s++) begin
			send_request(hbbc_pkg::OP_RELEASE, 8'd0, 32'd0, s[4:0], 32'd12);
			send_request(hbbc_pkg::OP_PIN, 8'd0, 32'd0, s[4:0], 32'd12);
			send_request(hbbc_pkg::OP_UNPIN, 8'd0, 32'd0, s[4:0], 32'd12);
		end
		// Buffer 0 was released at 11; a get at time 5 must not take it.
		send_request(hbbc_pkg::OP_GET, 8'd7, 32'd5, 5'd0, 32'd5);
		send_request(hbbc_pkg::OP_GET, 8'd0, 32'd0, 5'd0, 32'd20);
		drain();
	endtask

	// Holds every buffer so that a miss finds nothing to evict, then lets go.
	task automatic test_exhaustion();
		for (int i = 0; i < NBUF + 2; i++)
			send_request(hbbc_pkg::OP_GET, 8'd3, 32'd1000 + i * 31, 5'd0, 32'd30);
		for (int i = 0; i < NBUF; i++)
			for (int k = 0; k < 4; k++)
				send_request(hbbc_pkg::OP_RELEASE, 8'd0, 32'd0, i[4:0], 32'd40 + (i % 7));
		send_request(hbbc_pkg::OP_GET, 8'd4, 32'd77, 5'd0, 32'd38);
		send_request(hbbc_pkg::OP_GET, 8'd4, 32'd77, 5'd0, 32'd43);
		send_request(hbbc_pkg::OP_GET, 8'd3, 32'd1000, 5'd0, 32'd50);
		drain();
	endtask

	// Drives one count up to its ceiling and back down past zero.
	task automatic test_count_limits();
		for (int i = 0; i < 260; i++)
			send_request(hbbc_pkg::OP_PIN, 8'd0, 32'd0, 5'd17, 32'd60);
		send_request(hbbc_pkg::OP_GET, 8'd0, 32'd0, 5'd0, 32'd60);
		for (int i = 0; i < 258; i++)
			send_request((i % 2) ? hbbc_pkg::OP_UNPIN : hbbc_pkg::OP_RELEASE,
				8'd0, 32'd0, 5'd17, 32'd61);
		drain();
	endtask

	// Mostly a small block pool so hits, chains and evictions interleave.
	task automatic test_random_traffic(int count);
		hbbc_pkg::op_t op;
		logic [31:0] blk;
		logic [31:0] now;
		int pick;
		for (int n = 0; n < count; n++) begin
			quiet = (n < 300);
			pick = $urandom_range(99);
			op = pick < 40 ? hbbc_pkg::OP_GET : pick < 65 ? hbbc_pkg::OP_RELEASE :
				pick < 75 ? hbbc_pkg::OP_PIN : hbbc_pkg::OP_UNPIN;
			blk = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 70);
			clock_now = clock_now + $urandom_range(0, 5);
			now = ($urandom_range(9) == 0) ? $urandom : clock_now;
			send_request(op, ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
				blk, 5'($urandom_range(0, 31)), now);
		end
		drain();
		quiet = 1'b0;
	endtask

	initial begin
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_exhaustion();
		test_count_limits();
		test_random_traffic(1200);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#50ms;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
